// ----- sv/bfu_pkg.sv -----
// Shared types, field widths and constants for the bilinear frame upscaler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bfu_pkg;

  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 13;
  localparam int IDX_W     = 19;
  localparam int COLOR_W   = 24;
  localparam int PIXEL_W   = 32;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 3;
  localparam int FRAC_W    = 8;

  localparam int SRC_WIDTH_DEF   = 640;
  localparam int SRC_HEIGHT_DEF  = 480;
  localparam int MAX_COLUMNS_DEF = 4096;

  localparam logic [CFG_W-1:0]  DST_WIDTH_RST  = 14'd640;
  localparam logic [CFG_W-1:0]  DST_HEIGHT_RST = 14'd480;
  localparam logic [FRAC_W-1:0] FRAC_MAX       = 8'hFF;
  localparam logic [FRAC_W:0]   FRAC_ONE       = 9'd256;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE   = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DST_WIDTH  = 2'd0,
    CFG_DST_HEIGHT = 2'd1
  } cfg_index_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

endpackage

`default_nettype wire

// ----- sv/bfu_map.sv -----
// Pipelined coordinate mapper: destination coordinate to source position and fraction.
// Restoring division, one quotient bit per stage. Depends on bfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfu_map #(
  parameter int SRC_SIZE = 640,
  parameter int COORD_W  = 13,
  parameter int QW       = 18,
  parameter int IPW      = 10
) (
  input  logic                         clk,
  input  logic [COORD_W-1:0]           coord,
  input  logic [bfu_pkg::CFG_W-1:0]    dst_size,
  output logic [IPW-1:0]               pos,
  output logic [bfu_pkg::FRAC_W-1:0]   frac
);
  import bfu_pkg::*;

  localparam int SW   = $clog2(SRC_SIZE + 1);
  localparam int PW   = COORD_W + SW;
  localparam int LW   = CFG_W + SW;
  localparam int CMPW = (PW > LW) ? PW : LW;
  localparam int NW   = PW + FRAC_W;

  logic [CFG_W-1:0] div_eff;
  logic [PW-1:0]    prod_r;
  logic [LW-1:0]    lim_r;
  logic [NW-1:0]    num;

  logic [CFG_W-1:0] rem_r   [QW];
  logic [QW-1:0]    low_r   [QW];
  logic [QW-1:0]    quo_r   [QW+1];
  logic             clamp_r [QW+1];

  logic [CFG_W-1:0] rem_nxt [QW];
  logic             bit_nxt [QW];

  // A zero size behaves as one.
  assign div_eff = (dst_size == '0) ? CFG_W'(1) : dst_size;
  assign num     = {prod_r, FRAC_W'(0)};

  always_comb begin
    logic [CFG_W:0] trial;
    for (int k = 0; k < QW; k++) begin
      trial = {rem_r[k], low_r[k][QW-1]};
      if (trial >= {1'b0, div_eff}) begin
        rem_nxt[k] = CFG_W'(trial - {1'b0, div_eff});
        bit_nxt[k] = 1'b1;
      end else begin
        rem_nxt[k] = CFG_W'(trial);
        bit_nxt[k] = 1'b0;
      end
    end
  end

  // The position saturates when coord*S >= (S-1)*D; otherwise the quotient
  // coord*S*256/D fits in QW bits and the remainder starts below D.
  always_ff @(posedge clk) begin
    prod_r     <= PW'(coord) * PW'(SRC_SIZE);
    lim_r      <= LW'(div_eff) * LW'(SRC_SIZE - 1);
    rem_r[0]   <= CFG_W'(num >> QW);
    low_r[0]   <= QW'(num);
    quo_r[0]   <= '0;
    clamp_r[0] <= CMPW'(prod_r) >= CMPW'(lim_r);
    for (int k = 0; k < QW; k++) begin
      quo_r[k+1]   <= {quo_r[k][QW-2:0], bit_nxt[k]};
      clamp_r[k+1] <= clamp_r[k];
    end
    for (int k = 0; k < QW - 1; k++) begin
      rem_r[k+1] <= rem_nxt[k];
      low_r[k+1] <= low_r[k] << 1;
    end
  end

  assign pos  = clamp_r[QW] ? IPW'(SRC_SIZE - 2) : IPW'(quo_r[QW] >> FRAC_W);
  assign frac = clamp_r[QW] ? FRAC_MAX : quo_r[QW][FRAC_W-1:0];

endmodule

`default_nettype wire

// ----- sv/bilinear_frame_upscaler.sv -----
// Top level of the bilinear frame upscaler: frame store banks, write address
// split, blend pipeline and configuration registers. Depends on bfu_pkg and bfu_map.
`timescale 1ns / 1ps
`default_nettype none

// One request is taken in every clock cycle while busy is low, and busy is low
// at all times after reset. A read request returns its pixel on out_pixel_color
// with out_valid high for one cycle. The pipeline depth is set by the coordinate
// dividers, which resolve one quotient bit per stage for a quotient of
// QW = max(clog2(SRC_WIDTH), clog2(SRC_HEIGHT)) + 8 bits. Write requests return
// nothing and travel the same pipeline, so every request sees the frame exactly
// as the requests before it left it. Results cannot be held off: the receiver
// must take each one in the cycle it is shown. The frame is split into four
// banks by row and column parity so that the four neighbors of a pixel are read
// in the same cycle. Configuration must be written only while no request is in
// flight; the block itself does not enforce it.
module bilinear_frame_upscaler #(
  parameter int SRC_WIDTH   = bfu_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT  = bfu_pkg::SRC_HEIGHT_DEF,
  parameter int MAX_COLUMNS = bfu_pkg::MAX_COLUMNS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_operation,
  input  logic [bfu_pkg::IDX_W-1:0]       in_src_index,
  input  logic [bfu_pkg::COLOR_W-1:0]     in_src_color,
  input  logic [bfu_pkg::COORD_W-1:0]     in_dst_x,
  input  logic [bfu_pkg::COORD_W-1:0]     in_dst_y,
  output logic                            out_valid,
  output logic [bfu_pkg::PIXEL_W-1:0]     out_pixel_color,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfu_pkg::CFG_W-1:0]       cfg_data
);
  import bfu_pkg::*;

  localparam int CLW     = $clog2(SRC_WIDTH);
  localparam int RW      = $clog2(SRC_HEIGHT);
  localparam int QW      = ((CLW > RW) ? CLW : RW) + FRAC_W;
  localparam int MAP_LAT = QW + 2;
  localparam int LST     = MAP_LAT - 1;
  localparam int WL      = MAP_LAT - 2;

  localparam longint unsigned FRAME_DEPTH = longint'(SRC_WIDTH) * longint'(SRC_HEIGHT);
  // Exact division by the source width: floor(idx * RM / 2^RK).
  localparam int RK  = IDX_W + $clog2(SRC_WIDTH);
  localparam longint unsigned RM =
    ((64'd1 << RK) + longint'(SRC_WIDTH) - 64'd1) / longint'(SRC_WIDTH);
  localparam int RMW = IDX_W + 2;
  localparam int PRW = IDX_W + RMW;

  localparam int NBANK  = 4;
  localparam int HW     = (SRC_WIDTH + 1) / 2;
  localparam int HH     = (SRC_HEIGHT + 1) / 2;
  localparam int BDEPTH = HW * HH;
  localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

  function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b,
                                                   input logic [FRAC_W-1:0] f);
    logic [FRAC_W:0]     g;
    logic [2*CHAN_W:0]   s;
    g = FRAC_ONE - (FRAC_W + 1)'(f);
    s = (2*CHAN_W + 1)'(a) * (2*CHAN_W + 1)'(g) + (2*CHAN_W + 1)'(b) * (2*CHAN_W + 1)'(f);
    return s[2*CHAN_W-1:CHAN_W];
  endfunction

  // Control state.
  logic             busy_r;
  logic [CFG_W-1:0] dst_width_r;
  logic [CFG_W-1:0] dst_height_r;
  logic             rdv_r [MAP_LAT];
  logic             wrv_r [MAP_LAT];
  logic             we_r  [NBANK];
  logic             rda_r;
  logic             rdb_r;
  logic             rdc_r;
  logic             rdd_r;

  // Payload.
  logic [PRW-1:0]     prodw_r;
  logic [IDX_W-1:0]   idx0_r;
  logic [IDX_W-1:0]   idx1_r;
  logic [RW-1:0]      row1_r;
  logic [RW-1:0]      wrow_r  [WL];
  logic [CLW-1:0]     wcol_r  [WL];
  logic [COLOR_W-1:0] color_r [MAP_LAT];
  logic [BAW-1:0]     addr_r  [NBANK];
  logic [COLOR_W-1:0] wdat_r;
  logic               xa_r, ya_r, xb_r, yb_r;
  logic [FRAC_W-1:0]  fxa_r, fya_r, fxb_r, fyb_r, fyc_r;
  logic [CHAN_W-1:0]  tch_r [NUM_CHAN];
  logic [CHAN_W-1:0]  bch_r [NUM_CHAN];
  logic [CHAN_W-1:0]  pix_r [NUM_CHAN];

  logic               accept;
  logic [COORD_W-1:0] x_map;
  logic               in_range;
  logic [CLW-1:0]     xpos;
  logic [RW-1:0]      ypos;
  logic [FRAC_W-1:0]  xfrac;
  logic [FRAC_W-1:0]  yfrac;
  logic [CLW-1:0]     wcol_nxt;
  logic [BAW-1:0]     addr_nxt [NBANK];
  logic               we_nxt   [NBANK];
  logic [COLOR_W-1:0] rdat     [NBANK];
  logic [CHAN_W-1:0]  tch_nxt  [NUM_CHAN];
  logic [CHAN_W-1:0]  bch_nxt  [NUM_CHAN];
  logic [CHAN_W-1:0]  pix_nxt  [NUM_CHAN];

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;
  assign accept    = start & ~busy_r;
  assign x_map     = (in_dst_x >= MAX_COLUMNS) ? COORD_W'(MAX_COLUMNS - 1) : in_dst_x;
  assign in_range  = 64'(in_src_index) < FRAME_DEPTH;

  bfu_map #(
    .SRC_SIZE (SRC_WIDTH),
    .COORD_W  (COORD_W),
    .QW       (QW),
    .IPW      (CLW)
  ) u_map_x (
    .clk      (clk),
    .coord    (x_map),
    .dst_size (dst_width_r),
    .pos      (xpos),
    .frac     (xfrac)
  );

  bfu_map #(
    .SRC_SIZE (SRC_HEIGHT),
    .COORD_W  (COORD_W),
    .QW       (QW),
    .IPW      (RW)
  ) u_map_y (
    .clk      (clk),
    .coord    (in_dst_y),
    .dst_size (dst_height_r),
    .pos      (ypos),
    .frac     (yfrac)
  );

  assign wcol_nxt = CLW'(idx1_r - IDX_W'(32'(row1_r) * 32'(SRC_WIDTH)));

  // Bank {row parity, column parity}. For a read, the even bank of each axis
  // holds the neighbor one half step further when the base coordinate is odd.
  always_comb begin
    logic [1:0]     bsel;
    logic [RW-1:0]  rhalf;
    logic [CLW-1:0] chalf;
    for (int b = 0; b < NBANK; b++) begin
      bsel = 2'(b);
      if (wrv_r[LST]) begin
        rhalf = wrow_r[WL-1] >> 1;
        chalf = wcol_r[WL-1] >> 1;
      end else begin
        rhalf = (ypos >> 1) + (bsel[1] ? RW'(0) : RW'(ypos[0]));
        chalf = (xpos >> 1) + (bsel[0] ? CLW'(0) : CLW'(xpos[0]));
      end
      addr_nxt[b] = BAW'(32'(rhalf) * 32'(HW) + 32'(chalf));
      we_nxt[b]   = wrv_r[LST] && (wrow_r[WL-1][0] == bsel[1])
                    && (wcol_r[WL-1][0] == bsel[0]);
    end
  end

  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    logic [COLOR_W-1:0] frame_mem [BDEPTH];
    logic [COLOR_W-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (we_r[b]) begin
        frame_mem[addr_r[b]] <= wdat_r;
      end
      rd_r <= frame_mem[addr_r[b]];
    end

    assign rdat[b] = rd_r;
  end

  always_comb begin
    logic [COLOR_W-1:0] tl, tr, bl, br;
    tl = rdat[{yb_r, xb_r}];
    tr = rdat[{yb_r, ~xb_r}];
    bl = rdat[{~yb_r, xb_r}];
    br = rdat[{~yb_r, ~xb_r}];
    for (int c = 0; c < NUM_CHAN; c++) begin
      tch_nxt[c] = blend_chan(tl[c*CHAN_W +: CHAN_W], tr[c*CHAN_W +: CHAN_W], fxb_r);
      bch_nxt[c] = blend_chan(bl[c*CHAN_W +: CHAN_W], br[c*CHAN_W +: CHAN_W], fxb_r);
      pix_nxt[c] = blend_chan(tch_r[c], bch_r[c], fyc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      dst_width_r  <= DST_WIDTH_RST;
      dst_height_r <= DST_HEIGHT_RST;
      for (int k = 0; k < MAP_LAT; k++) begin
        rdv_r[k] <= 1'b0;
        wrv_r[k] <= 1'b0;
      end
      for (int b = 0; b < NBANK; b++) begin
        we_r[b] <= 1'b0;
      end
      rda_r <= 1'b0;
      rdb_r <= 1'b0;
      rdc_r <= 1'b0;
      rdd_r <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DST_WIDTH) begin
          dst_width_r <= cfg_data;
        end
        if (cfg_index == CFG_DST_HEIGHT) begin
          dst_height_r <= cfg_data;
        end
      end
      // Out-of-range writes are dropped here and never reach the banks.
      rdv_r[0] <= accept && (in_operation == OP_READ);
      wrv_r[0] <= accept && (in_operation == OP_WRITE) && in_range;
      for (int k = 1; k < MAP_LAT; k++) begin
        rdv_r[k] <= rdv_r[k-1];
        wrv_r[k] <= wrv_r[k-1];
      end
      for (int b = 0; b < NBANK; b++) begin
        we_r[b] <= we_nxt[b];
      end
      rda_r <= rdv_r[LST];
      rdb_r <= rda_r;
      rdc_r <= rdb_r;
      rdd_r <= rdc_r;
    end
  end

  always_ff @(posedge clk) begin
    prodw_r    <= PRW'(in_src_index) * PRW'(RM);
    idx0_r     <= in_src_index;
    color_r[0] <= in_src_color;
    for (int k = 1; k < MAP_LAT; k++) begin
      color_r[k] <= color_r[k-1];
    end
    idx1_r    <= idx0_r;
    row1_r    <= RW'(prodw_r >> RK);
    wrow_r[0] <= row1_r;
    wcol_r[0] <= wcol_nxt;
    for (int k = 1; k < WL; k++) begin
      wrow_r[k] <= wrow_r[k-1];
      wcol_r[k] <= wcol_r[k-1];
    end
    for (int b = 0; b < NBANK; b++) begin
      addr_r[b] <= addr_nxt[b];
    end
    wdat_r <= color_r[LST];
    xa_r   <= xpos[0];
    ya_r   <= ypos[0];
    fxa_r  <= xfrac;
    fya_r  <= yfrac;
    xb_r   <= xa_r;
    yb_r   <= ya_r;
    fxb_r  <= fxa_r;
    fyb_r  <= fya_r;
    fyc_r  <= fyb_r;
    for (int c = 0; c < NUM_CHAN; c++) begin
      tch_r[c] <= tch_nxt[c];
      bch_r[c] <= bch_nxt[c];
      pix_r[c] <= pix_nxt[c];
    end
  end

  assign out_valid       = rdd_r;
  assign out_pixel_color = {ALPHA_OPAQUE, pix_r[2], pix_r[1], pix_r[0]};

endmodule

`default_nettype wire

// ----- verif/tb_bilinear_frame_upscaler.sv -----
// Self-checking testbench for bilinear_frame_upscaler: writes source pixels,
// requests interpolated pixels under several destination sizes and checks each one.
// Depends on bfu_pkg and the bilinear_frame_upscaler RTL.
`timescale 1ns / 1ps

module tb_bilinear_frame_upscaler;
  import bfu_pkg::*;

  localparam int SRC_W        = SRC_WIDTH_DEF;
  localparam int SRC_H        = SRC_HEIGHT_DEF;
  localparam int FRAME_DEPTH  = SRC_W * SRC_H;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pix_req_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               start           = 1'b0;
  logic               busy;
  logic               in_operation    = 1'b0;
  logic [IDX_W-1:0]   in_src_index    = '0;
  logic [COLOR_W-1:0] in_src_color    = '0;
  logic [COORD_W-1:0] in_dst_x        = '0;
  logic [COORD_W-1:0] in_dst_y        = '0;
  logic               out_valid;
  logic [PIXEL_W-1:0] out_pixel_color;
  logic               cfg_valid       = 1'b0;
  logic               cfg_ready;
  cfg_index_t         cfg_index       = CFG_DST_WIDTH;
  logic [CFG_W-1:0]   cfg_data        = '0;

  // Predictor state: the frame as the block holds it and the destination size.
  bit [COLOR_W-1:0] frame_mem [FRAME_DEPTH];
  logic [CFG_W-1:0] dst_w_reg = DST_WIDTH_RST;
  logic [CFG_W-1:0] dst_h_reg = DST_HEIGHT_RST;

  // Tracks which source pixels the stimulus has already written.
  bit frame_filled [FRAME_DEPTH];

  int unsigned nb_ofs[4] = '{0, 1, SRC_W, SRC_W + 1};

  pix_req_t           req_q[$];
  logic [PIXEL_W-1:0] pixel_exp_q[$];
  pix_req_t           req_now;
  int                 idle_pct     = 10;
  int                 burst_left   = 0;
  int                 mismatch_cnt = 0;

  always #1 clk = ~clk;

  bilinear_frame_upscaler u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_src_index    (in_src_index),
    .in_src_color    (in_src_color),
    .in_dst_x        (in_dst_x),
    .in_dst_y        (in_dst_y),
    .out_valid       (out_valid),
    .out_pixel_color (out_pixel_color),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Maps a destination coordinate to a source base position and 8-bit fraction.
  function automatic void map_axis(input int unsigned coord, input int unsigned src,
                                   input logic [CFG_W-1:0] dsize,
                                   output int unsigned pos, output logic [FRAC_W-1:0] frac);
    longint unsigned d;
    longint unsigned p;
    d = (dsize == 0) ? 64'd1 : 64'(dsize);
    p = ((64'(coord) * 64'(src)) << 16) / d;
    pos = int'(p >> 16);
    frac = p[15:8];
    // The last source pixel has no right or lower neighbor, so stay one short.
    if (p >> 16 >= 64'(src - 1)) begin
      pos = src - 2;
      frac = FRAC_MAX;
    end
  endfunction

  function automatic logic [COLOR_W-1:0] mix_rgb(input logic [COLOR_W-1:0] a,
                                                 input logic [COLOR_W-1:0] b,
                                                 input logic [FRAC_W-1:0] f);
    logic [FRAC_W:0]    g;
    logic [16:0]        acc;
    logic [COLOR_W-1:0] res;
    g = FRAC_ONE - f;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      acc = a[ch*CHAN_W +: CHAN_W] * g + b[ch*CHAN_W +: CHAN_W] * f;
      res[ch*CHAN_W +: CHAN_W] = acc[15:8];
    end
    return res;
  endfunction

  function automatic int unsigned clamp_column(input logic [COORD_W-1:0] x);
    return (x >= MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF - 1 : int'(x);
  endfunction

  function automatic logic [PIXEL_W-1:0] upscale_pixel(input logic [COORD_W-1:0] x,
                                                       input logic [COORD_W-1:0] y);
    int unsigned        x0;
    int unsigned        y0;
    int unsigned        base;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;
    logic [COLOR_W-1:0] top;
    logic [COLOR_W-1:0] bot;
    map_axis(clamp_column(x), SRC_W, dst_w_reg, x0, fx);
    map_axis(y, SRC_H, dst_h_reg, y0, fy);
    base = y0 * SRC_W + x0;
    top = mix_rgb(frame_mem[base], frame_mem[base + 1], fx);
    bot = mix_rgb(frame_mem[base + SRC_W], frame_mem[base + SRC_W + 1], fx);
    return {ALPHA_OPAQUE, mix_rgb(top, bot, fy)};
  endfunction

  function automatic logic [COLOR_W-1:0] rand_color();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return COLOR_W'($urandom());
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input logic [CFG_W-1:0] dsize);
    int unsigned lim;
    lim = (dsize == 0) ? 1 : dsize;
    if (lim > 8192) lim = 8192;
    case ($urandom_range(0, 5))
      0, 1:    return COORD_W'($urandom_range(0, lim - 1));
      2:       return COORD_W'($urandom_range(0, 1) ? 0 : lim - 1);
      3:       return COORD_W'(MAX_COLUMNS_DEF - 1 + $urandom_range(0, 1));
      default: return COORD_W'($urandom_range(0, 8191));
    endcase
  endfunction

  task automatic add_write(input int unsigned idx, input logic [COLOR_W-1:0] color);
    pix_req_t r;
    r.op    = OP_WRITE;
    r.idx   = IDX_W'(idx);
    r.color = color;
    r.x     = COORD_W'($urandom());
    r.y     = COORD_W'($urandom());
    if (idx < FRAME_DEPTH) frame_filled[idx] = 1'b1;
    req_q.push_back(r);
  endtask

  // A read request is preceded by writes to any of its four source neighbors
  // that still hold no value.
  task automatic add_read(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    pix_req_t          r;
    int unsigned       x0;
    int unsigned       y0;
    int unsigned       base;
    int unsigned       nb;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    map_axis(clamp_column(x), SRC_W, dst_w_reg, x0, fx);
    map_axis(y, SRC_H, dst_h_reg, y0, fy);
    base = y0 * SRC_W + x0;
    foreach (nb_ofs[i]) begin
      nb = base + nb_ofs[i];
      if (!frame_filled[nb]) add_write(nb, rand_color());
    end
    r.op    = OP_READ;
    r.idx   = IDX_W'($urandom());
    r.color = COLOR_W'($urandom());
    r.x     = x;
    r.y     = y;
    req_q.push_back(r);
  endtask

  task automatic random_requests(input int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        add_read(pick_coord(dst_w_reg), pick_coord(dst_h_reg));
      end else if (sel < 90) begin
        add_write($urandom_range(0, FRAME_DEPTH - 1), rand_color());
      end else begin
        add_write($urandom_range(FRAME_DEPTH, (1 << IDX_W) - 1), rand_color());
      end
    end
  endtask

  // Writes only complete silently, so wait out the pipeline after the last pixel.
  task automatic drain();
    while (req_q.size() != 0 || start || pixel_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DST_WIDTH) dst_w_reg = val;
    else dst_h_reg = val;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int pct, input int n);
    write_cfg(CFG_DST_WIDTH, w);
    write_cfg(CFG_DST_HEIGHT, h);
    idle_pct = pct;
    random_requests(n);
    drain();
  endtask

  // Driver: holds a request until it is taken, then loads the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      start        <= 1'b0;
      in_operation <= 1'b0;
      in_src_index <= '0;
      in_src_color <= '0;
      in_dst_x     <= '0;
      in_dst_y     <= '0;
    end else begin
      if (start && !busy) begin
        if (req_now.op == OP_READ) begin
          pixel_exp_q.push_back(upscale_pixel(req_now.x, req_now.y));
        end else if (req_now.idx < FRAME_DEPTH) begin
          frame_mem[req_now.idx] = req_now.color;
        end
      end
      if (!start || !busy) begin
        if (burst_left > 0) burst_left--;
        else if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(8, 40);
        if (req_q.size() > 0 && (burst_left > 0 || $urandom_range(0, 99) >= idle_pct)) begin
          req_now = req_q.pop_front();
          start        <= 1'b1;
          in_operation <= req_now.op;
          in_src_index <= req_now.idx;
          in_src_color <= req_now.color;
          in_dst_x     <= req_now.x;
          in_dst_y     <= req_now.y;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed pixel must match the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pixel_exp_q.size() == 0) begin
        $error("out_pixel_color: expected none, actual %h", out_pixel_color);
        mismatch_cnt++;
      end else if (out_pixel_color !== pixel_exp_q[0]) begin
        $error("out_pixel_color: expected %h, actual %h", pixel_exp_q[0], out_pixel_color);
        mismatch_cnt++;
        void'(pixel_exp_q.pop_front());
      end else begin
        void'(pixel_exp_q.pop_front());
      end
    end
  end

  // Most reads bring up to four neighbor writes with them, so the request
  // counts below are kept to about a third of the intended item total.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size first, with frame corners, saturated colors and ignored writes.
    idle_pct = 10;
    add_write(0, 24'h000000);
    add_write(1, 24'hFFFFFF);
    add_write(SRC_W, 24'hFF00FF);
    add_write(SRC_W + 1, 24'h00FF00);
    add_read(0, 0);
    add_read(1, 1);
    add_write(FRAME_DEPTH, 24'h123456);
    add_write((1 << IDX_W) - 1, 24'hFFFFFF);
    add_write(FRAME_DEPTH - 1, 24'hABCDEF);
    add_read(SRC_W - 1, SRC_H - 1);
    add_read(MAX_COLUMNS_DEF - 1, 100);
    add_read(MAX_COLUMNS_DEF, 100);
    add_read(13'h1FFF, 13'h1FFF);
    add_read(700, 500);
    add_read(320, 240);
    random_requests(70);
    drain();

    run_phase(14'd1, 14'd1, 10, 30);
    run_phase(14'h3FFF, 14'h3FFF, 10, 50);
    run_phase(14'd1280, 14'd960, 68, 70);
    run_phase(14'd8192, 14'd0, 68, 50);
    run_phase(14'd320, 14'd240, 0, 70);
    run_phase(CFG_W'($urandom_range(1, 2000)), CFG_W'($urandom_range(1, 2000)), 0, 50);

    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
